/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define STP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define STP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/stp_pkg.sv */
package stp_pkg;

    localparam int NUM_SYMBOLS = 4;
    localparam int COUNT_BITS  = 16;
    localparam int TOTAL_BITS  = COUNT_BITS + 2;
    localparam int SYM_BITS    = 2;
    localparam int CFG_BITS    = 6;
    localparam int MISS_BITS   = 6;

    // APB register index, decoded from paddr[2] (byte address 4 * index)
    localparam logic REG_MISS_THRESHOLD = 1'b0;
    localparam logic REG_WINDOW_LENGTH  = 1'b1;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [TOTAL_BITS-1:0] total_t;
    typedef logic [SYM_BITS-1:0]   symbol_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_TIE    = 2'd1,
        KIND_UNIQUE = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t   kind;
        symbol_t pred;
    } class_t;

endpackage

/* rtl/substitution_tolerant_predictor.sv */
// Substitution-tolerant context predictor.
// Input stream (s_*): one beat per coded symbol, carrying the four context
// counters, their kept sum and the symbol that occurred. Output stream (m_*):
// one beat per input beat, in order, with the active flag, prediction kind,
// predicted symbol, history override flag and the miss count of the window.
// APB port: register 0 (byte 0x0) miss_threshold, register 1 (byte 0x4)
// window_length; write only while the stream is idle.
// A beat accepted into the input register moves on to the result register
// when that is empty or being taken, and is offered on m_* from there.
// Throughput: one beat per cycle while m_tready is high. The argmax, the
// window popcount and the window/flag update sit between the input register
// and the result register; window state updates as each result is loaded.
// Stall: when m_tready is low the result register holds; the input register
// still takes one more beat, then s_tready drops until the result drains.
// Reset: model off, miss window all zeros, miss_threshold 0,
// window_length 32, both pipeline stages empty.
`include "assert_macros.svh"

module substitution_tolerant_predictor #(
    parameter int MAX_WINDOW = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // count_a, count_b, count_c, count_d, count_total, actual_symbol, zero pad
    input  logic [87:0] s_tdata,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // model_active, predicted_symbol, override_valid, miss_count, zero pad
    output logic [15:0] m_tdata,
    // prediction_kind
    output logic [1:0]  m_tuser
);
    import stp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;
    localparam int PAD_W  = 16 - 1 - SYM_BITS - 1 - MISS_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_BITS-1:0] miss_threshold_reg;
    logic [CFG_BITS-1:0] window_length_reg;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_threshold_reg <= '0;
            window_length_reg  <= CFG_BITS'(32);
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_MISS_THRESHOLD: miss_threshold_reg <= pwdata[CFG_BITS-1:0];
                REG_WINDOW_LENGTH:  window_length_reg  <= pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MISS_THRESHOLD: prdata = 32'(miss_threshold_reg);
            REG_WINDOW_LENGTH:  prdata = 32'(window_length_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register -> result register
    // ------------------------------------------------------------------
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    in_load;
    logic    out_load;

    count_t  in_count_a_reg;
    count_t  in_count_b_reg;
    count_t  in_count_c_reg;
    count_t  in_count_d_reg;
    total_t  in_total_reg;
    symbol_t in_symbol_reg;

    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                in_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_count_a_reg <= s_tdata[15:0];
            in_count_b_reg <= s_tdata[31:16];
            in_count_c_reg <= s_tdata[47:32];
            in_count_d_reg <= s_tdata[63:48];
            in_total_reg   <= s_tdata[81:64];
            in_symbol_reg  <= s_tdata[83:82];
        end
    end

    // ------------------------------------------------------------------
    // Prediction classification
    // ------------------------------------------------------------------
    class_t cls;

    stp_classify u_classify (
        .count_a     (in_count_a_reg),
        .count_b     (in_count_b_reg),
        .count_c     (in_count_c_reg),
        .count_d     (in_count_d_reg),
        .count_total (in_total_reg),
        .cls         (cls)
    );

    // ------------------------------------------------------------------
    // Hit/miss window and active flag
    // ------------------------------------------------------------------
    logic                  active_reg;
    logic                  active_next;
    logic [MAX_WINDOW-1:0] window_reg;
    logic [MAX_WINDOW-1:0] window_next;
    logic [MAX_WINDOW-1:0] win_mask;
    logic [MAX_WINDOW-1:0] win_push;
    logic [CNT_W-1:0]      len_eff;
    logic [CNT_W-1:0]      old_cnt;
    logic [CNT_W-1:0]      new_cnt;
    logic                  top_bit;
    logic                  do_push;
    logic                  do_clear;
    logic                  mark;
    logic                  miss_ok;
    logic                  ovr;

    // window_length above MAX_WINDOW clamps to MAX_WINDOW
    always_comb
    begin
        if ({1'b0, window_length_reg} >= (CFG_BITS + 1)'(MAX_WINDOW))
        begin
            len_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            len_eff = CNT_W'(window_length_reg);
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            win_mask[k] = (CNT_W'(k) < len_eff);
        end
    end

    // marks currently inside the window
    always_comb
    begin
        old_cnt = '0;
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            old_cnt = old_cnt + CNT_W'(window_reg[k] & win_mask[k]);
        end
    end

    // oldest mark in the window; it drops out on a shift
    assign top_bit = |(window_reg & win_mask & ~(win_mask >> 1));
    assign miss_ok = CMP_W'(old_cnt) <= CMP_W'(miss_threshold_reg);
    assign win_push = (window_reg & ~win_mask)
                    | (((window_reg << 1) | MAX_WINDOW'(mark)) & win_mask);

    always_comb
    begin
        active_next = active_reg;
        do_push     = 1'b0;
        do_clear    = 1'b0;
        mark        = 1'b0;
        ovr         = 1'b0;
        case (cls.kind)
            KIND_NONE:
            begin
                do_push = active_reg;
            end
            KIND_TIE:
            begin
                if (active_reg)
                begin
                    if (miss_ok)
                    begin
                        do_push = 1'b1;
                        mark    = 1'b1;
                    end
                    else
                    begin
                        active_next = 1'b0;
                    end
                end
            end
            KIND_UNIQUE:
            begin
                if (!active_reg)
                begin
                    active_next = 1'b1;
                    do_clear    = 1'b1;
                end
                else if (cls.pred == in_symbol_reg)
                begin
                    do_push = 1'b1;
                end
                else
                begin
                    ovr = 1'b1;
                    if (miss_ok)
                    begin
                        do_push = 1'b1;
                        mark    = 1'b1;
                    end
                    else
                    begin
                        active_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // count after the step follows from the shift: minus the dropped mark, plus the new one
    always_comb
    begin
        if (do_clear)
        begin
            window_next = window_reg & ~win_mask;
            new_cnt     = '0;
        end
        else if (do_push)
        begin
            window_next = win_push;
            new_cnt     = old_cnt - CNT_W'(top_bit) + CNT_W'(mark & win_mask[0]);
        end
        else
        begin
            window_next = window_reg;
            new_cnt     = old_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            window_reg <= '0;
        end
        else if (out_load)
        begin
            active_reg <= active_next;
            window_reg <= window_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                 out_active_reg;
    kind_t                out_kind_reg;
    symbol_t              out_pred_reg;
    logic                 out_ovr_reg;
    logic [MISS_BITS-1:0] out_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_active_reg <= active_next;
            out_kind_reg   <= cls.kind;
            out_pred_reg   <= cls.pred;
            out_ovr_reg    <= ovr;
            out_cnt_reg    <= MISS_BITS'(new_cnt);
        end
    end

    assign m_tdata = {{PAD_W{1'b0}}, out_cnt_reg, out_ovr_reg, out_pred_reg, out_active_reg};
    assign m_tuser = out_kind_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an override only comes with a unique best from an active model
    `STP_ASSERT_NOW(a_ovr_unique, out_valid_reg && out_ovr_reg,
        out_kind_reg == KIND_UNIQUE)
    // switching on starts from an empty window
    `STP_ASSERT_NEXT(a_switch_on_clears,
        out_load && !active_reg && cls.kind == KIND_UNIQUE,
        active_reg && out_cnt_reg == '0)
    // while off, anything but a unique best leaves the state alone
    `STP_ASSERT_NEXT(a_off_holds,
        out_load && !active_reg && cls.kind != KIND_UNIQUE,
        !active_reg && $stable(window_reg))
    // a full pipeline under backpressure takes no more beats
    `STP_ASSERT_NOW(a_full_stall, in_valid_reg && out_valid_reg && !m_tready,
        !s_tready)

endmodule

/* rtl/stp_classify.sv */
module stp_classify (
    input  stp_pkg::count_t count_a,
    input  stp_pkg::count_t count_b,
    input  stp_pkg::count_t count_c,
    input  stp_pkg::count_t count_d,
    input  stp_pkg::total_t count_total,
    output stp_pkg::class_t cls
);
    import stp_pkg::*;

    count_t                 cnt [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] is_max;
    symbol_t                best;

    assign cnt[0] = count_a;
    assign cnt[1] = count_b;
    assign cnt[2] = count_c;
    assign cnt[3] = count_d;

    // A counter is a maximum when nothing beats it; exactly one maximum is a unique best.
    always_comb
    begin
        for (int i = 0; i < NUM_SYMBOLS; i++)
        begin
            is_max[i] = 1'b1;
            for (int j = 0; j < NUM_SYMBOLS; j++)
            begin
                if (cnt[j] > cnt[i])
                begin
                    is_max[i] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        best = '0;
        for (int i = 0; i < NUM_SYMBOLS; i++)
        begin
            if (is_max[i])
            begin
                best = SYM_BITS'(i);
            end
        end
    end

    always_comb
    begin
        if (count_total == TOTAL_BITS'(NUM_SYMBOLS))
        begin
            cls.kind = KIND_NONE;
            cls.pred = '0;
        end
        else if ($onehot(is_max))
        begin
            cls.kind = KIND_UNIQUE;
            cls.pred = best;
        end
        else
        begin
            cls.kind = KIND_TIE;
            cls.pred = '0;
        end
    end

endmodule

/* tb/substitution_tolerant_predictor_tb.sv */
module substitution_tolerant_predictor_tb;

    import stp_pkg::*;

    // Clock period and run shape.
    localparam int CLK_HALF     = 5;
    localparam int WINDOW_MAX   = 32;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 8;
    localparam int HOLD_AT      = 400;   // beats sent before the long output hold-off
    localparam int HOLD_CYCLES  = 60;
    localparam int MAX_REPORTS  = 10;

    // Output-side stall patterns.
    typedef enum int {RX_OPEN, RX_BUSY, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    // One input beat, fields in natural order (packed onto s_tdata by offer_symbol).
    typedef struct packed {
        count_t  a;
        count_t  b;
        count_t  c;
        count_t  d;
        total_t  total;
        symbol_t sym;
    } item_t;

    // One output beat.
    typedef struct packed {
        logic        active;
        kind_t       kind;
        symbol_t     pred;
        logic        ovr;
        logic [5:0]  miss;
    } result_t;

    // Directed row: the beat, whether its result is typed in, and that result.
    typedef struct packed {
        item_t   it;
        bit      typed;
        result_t res;
    } row_t;

    // Configuration per phase: {miss_threshold, window_length}. Covers an empty
    // window, lengths and thresholds beyond the window limit, single-mark
    // window, the full window, then shrinking and growing it again.
    localparam int PHASE_CFG [NUM_PHASES][2] = '{
        '{0, 0}, '{63, 63}, '{1, 1}, '{32, 32},
        '{4, 8}, '{2, 20}, '{5, 40}, '{0, 1}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // count_a, count_b, count_c, count_d, count_total, actual_symbol, zero pad
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // model_active, predicted_symbol, override_valid, miss_count, zero pad
    logic [15:0] m_tdata;
    // prediction_kind
    logic [1:0]  m_tuser;

    // Predictor state and its copy of the registers.
    logic        model_on;
    logic [31:0] miss_marks;
    logic [5:0]  miss_thr;
    logic [5:0]  window_len;

    result_t outcome_q [$];        // expected results, oldest first
    int      error_cnt = 0;
    int      sent_cnt = 0;
    int      burst_left = 0;

    // Directed beats under the reset configuration (threshold 0, window 32).
    // Rows with typed results walk the basic flow: no counts, ties, turning
    // on, hit, miss, a second miss turning off, and re-activation clearing
    // the window. The last rows are left to the predictor.
    row_t directed_rows [20] = '{
        // sum equals symbol count: no counts, model stays off
        '{'{16'd5, 16'd9, 16'd0, 16'd0, 18'd4, 2'd1}, 1'b1,
          '{1'b0, KIND_NONE, 2'd0, 1'b0, 6'd0}},
        // all counters zero: tie
        '{'{16'd0, 16'd0, 16'd0, 16'd0, 18'd0, 2'd0}, 1'b1,
          '{1'b0, KIND_TIE, 2'd0, 1'b0, 6'd0}},
        // all counters at max: tie
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 18'h3FFFF, 2'd3}, 1'b1,
          '{1'b0, KIND_TIE, 2'd0, 1'b0, 6'd0}},
        // unique best while off: turns on
        '{'{16'hFFFF, 16'd0, 16'd0, 16'd0, 18'h3FFFF, 2'd0}, 1'b1,
          '{1'b1, KIND_UNIQUE, 2'd0, 1'b0, 6'd0}},
        // hit
        '{'{16'hFFFF, 16'd0, 16'd0, 16'd0, 18'h3FFFF, 2'd0}, 1'b1,
          '{1'b1, KIND_UNIQUE, 2'd0, 1'b0, 6'd0}},
        // miss, window empty so it stays on and overrides
        '{'{16'd1, 16'd1, 16'd1, 16'hFFFF, 18'd0, 2'd0}, 1'b1,
          '{1'b1, KIND_UNIQUE, 2'd3, 1'b1, 6'd1}},
        // no counts while on: shifts a zero
        '{'{16'd0, 16'd0, 16'd0, 16'd0, 18'd4, 2'd2}, 1'b1,
          '{1'b1, KIND_NONE, 2'd0, 1'b0, 6'd1}},
        // tie while on, one mark already over threshold: turns off
        '{'{16'd0, 16'd7, 16'd7, 16'd0, 18'd14, 2'd1}, 1'b1,
          '{1'b0, KIND_TIE, 2'd0, 1'b0, 6'd1}},
        // unique best turns on again and clears the window
        '{'{16'd0, 16'd100, 16'd0, 16'd0, 18'd0, 2'd2}, 1'b1,
          '{1'b1, KIND_UNIQUE, 2'd1, 1'b0, 6'd0}},
        '{'{16'd0, 16'd0, 16'h8000, 16'd0, 18'd0, 2'd1}, 1'b1,
          '{1'b1, KIND_UNIQUE, 2'd2, 1'b1, 6'd1}},
        // miss that turns the model off still overrides
        '{'{16'd0, 16'd0, 16'h8000, 16'd0, 18'd0, 2'd1}, 1'b1,
          '{1'b0, KIND_UNIQUE, 2'd2, 1'b1, 6'd1}},
        '{'{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 18'd0, 2'd0}, 1'b1,
          '{1'b0, KIND_TIE, 2'd0, 1'b0, 6'd1}},
        // sum of 4 wins over a unique best
        '{'{16'd0, 16'd0, 16'd0, 16'd9, 18'd4, 2'd3}, 1'b1,
          '{1'b0, KIND_NONE, 2'd0, 1'b0, 6'd1}},
        '{'{16'd0, 16'd0, 16'd0, 16'd1, 18'h3FFFF, 2'd3}, 1'b1,
          '{1'b1, KIND_UNIQUE, 2'd3, 1'b0, 6'd0}},
        // three-way tie, best at the top index, bit patterns, sums around 4
        '{'{16'd5, 16'd5, 16'd5, 16'd4, 18'd19, 2'd0}, 1'b0, '0},
        '{'{16'hFFFE, 16'd0, 16'd0, 16'hFFFF, 18'h1FFFD, 2'd3}, 1'b0, '0},
        '{'{16'h5555, 16'hAAAA, 16'd0, 16'd0, 18'h2AAAA, 2'd1}, 1'b0, '0},
        '{'{16'hAAAA, 16'h5555, 16'h1234, 16'hAAAA, 18'h15555, 2'd2}, 1'b0, '0},
        '{'{16'd3, 16'd0, 16'd0, 16'd0, 18'd5, 2'd0}, 1'b0, '0},
        '{'{16'd0, 16'd2, 16'd0, 16'd0, 18'd3, 2'd0}, 1'b0, '0}
    };

    substitution_tolerant_predictor u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Bits of the mark window that are in use; lengths past the limit clamp.
    function automatic logic [31:0] window_mask();
        int len;
        len = (int'(window_len) > WINDOW_MAX) ? WINDOW_MAX : int'(window_len);
        return (len >= 32) ? 32'hFFFF_FFFF : ((32'd1 << len) - 32'd1);
    endfunction

    // Shift a mark into the active part; bits above the window are kept.
    function automatic void shift_mark(logic mark);
        logic [31:0] m;
        m = window_mask();
        miss_marks = (miss_marks & ~m) | (((miss_marks << 1) | {31'd0, mark}) & m);
    endfunction

    // Miss or tie while on: record it, or switch off once over threshold.
    function automatic void count_miss();
        if ($countones(miss_marks & window_mask()) <= int'(miss_thr))
            shift_mark(1'b1);
        else
            model_on = 1'b0;
    endfunction

    function automatic result_t predict_outcome(item_t it);
        count_t  cnt [4];
        count_t  top;
        int      best;
        logic    tie;
        result_t r;
        cnt = '{it.a, it.b, it.c, it.d};
        r = '0;
        if (it.total == total_t'(NUM_SYMBOLS))
        begin
            r.kind = KIND_NONE;
        end
        else
        begin
            best = 0;
            top  = cnt[0];
            for (int i = 1; i < NUM_SYMBOLS; i++)
                if (cnt[i] > top)
                begin
                    top  = cnt[i];
                    best = i;
                end
            tie = 1'b0;
            for (int i = 0; i < NUM_SYMBOLS; i++)
                if (i != best && cnt[i] == top)
                    tie = 1'b1;
            if (tie)
            begin
                r.kind = KIND_TIE;
            end
            else
            begin
                r.kind = KIND_UNIQUE;
                r.pred = symbol_t'(best);
            end
        end

        case (r.kind)
            KIND_NONE:
                if (model_on)
                    shift_mark(1'b0);
            KIND_TIE:
                if (model_on)
                    count_miss();
            default:
                if (!model_on)
                begin
                    model_on   = 1'b1;
                    miss_marks = miss_marks & ~window_mask();
                end
                else if (r.pred == it.sym)
                begin
                    shift_mark(1'b0);
                end
                else
                begin
                    count_miss();
                    r.ovr = 1'b1;
                end
        endcase

        r.active = model_on;
        r.miss   = 6'($countones(miss_marks & window_mask()));
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Random beats: mostly unique bests with a high hit rate so the model
    // stays on and fills its window, plus ties, empty contexts and noise.
    // ---------------------------------------------------------------
    function automatic item_t random_symbol();
        item_t  it;
        count_t cnt [4];
        count_t top;
        int     pick;
        int     b1;
        int     b2;
        pick = $urandom_range(0, 99);
        top  = ($urandom_range(0, 2) == 0) ? count_t'($urandom_range(1, 15))
                                           : count_t'($urandom_range(1, 65535));
        b1   = $urandom_range(0, 3);
        b2   = (b1 + $urandom_range(1, 3)) % 4;
        it.total = total_t'($urandom_range(0, 262143));
        it.sym   = symbol_t'($urandom_range(0, 3));
        if (pick < 55)
        begin
            // unique best, usually a hit
            for (int i = 0; i < 4; i++)
                cnt[i] = (i == b1) ? top : count_t'($urandom_range(0, int'(top) - 1));
            if ($urandom_range(0, 9) < 7)
                it.sym = symbol_t'(b1);
        end
        else if (pick < 70)
        begin
            // two or more counters share the maximum
            for (int i = 0; i < 4; i++)
                cnt[i] = (i == b1 || i == b2) ? top : count_t'($urandom_range(0, int'(top)));
        end
        else if (pick < 85)
        begin
            // empty context
            for (int i = 0; i < 4; i++)
                cnt[i] = count_t'($urandom_range(0, 65535));
            it.total = total_t'(NUM_SYMBOLS);
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                cnt[i] = count_t'($urandom_range(0, 65535));
        end
        it.a = cnt[0];
        it.b = cnt[1];
        it.c = cnt[2];
        it.d = cnt[3];
        return it;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // APB write: setup cycle, then access cycle; pready is tied high.
    // Upper data bits carry noise, only the low six are kept.
    task automatic apb_write(input logic idx, input int value);
        logic [31:0] word;
        word = {$urandom} << 6 | 32'(value & 63);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MISS_THRESHOLD)
            miss_thr = word[5:0];
        else
            window_len = word[5:0];
    endtask

    // Offer one beat until taken, then log its expected result. Between
    // bursts tvalid may drop for a random gap; inside a burst it stays high.
    task automatic offer_symbol(input item_t it, input bit typed, input result_t res);
        result_t r;
        int      gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, it.sym, it.total, it.d, it.c, it.b, it.a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = predict_outcome(it);
        outcome_q.push_back(typed ? res : r);
        sent_cnt++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Let the block drain before touching its registers.
    task automatic wait_idle();
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        model_on   = 1'b0;
        miss_marks = '0;
        miss_thr   = '0;
        window_len = 6'd32;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_symbol(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);
        s_tvalid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            apb_write(REG_MISS_THRESHOLD, PHASE_CFG[p][0]);
            apb_write(REG_WINDOW_LENGTH, PHASE_CFG[p][1]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_symbol(random_symbol(), 1'b0, '0);
            s_tvalid <= 1'b0;
        end

        // drain, then wait for any stray beat
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_cnt == 0 && outcome_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Output side: segments of different stall patterns, plus one long
    // hold-off while input keeps coming so both pipeline stages fill up.
    // ---------------------------------------------------------------
    initial
    begin
        rx_mode_t mode;
        int       seg;
        bit       held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && sent_cnt >= HOLD_AT)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = rx_mode_t'($urandom_range(0, 3));
            seg  = $urandom_range(1, 40);
            repeat (seg)
            begin
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_BUSY:   m_tready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ~m_tready;
                endcase
                @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // Result checker: every taken beat against the oldest expectation.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[0], kind_t'(m_tuser), m_tdata[2:1], m_tdata[3], m_tdata[9:4]};
            if (outcome_q.size() == 0)
            begin
                error_cnt++;
                if (error_cnt <= MAX_REPORTS)
                    $display("unexpected beat: active=%0d kind=%0d pred=%0d ovr=%0d miss=%0d",
                             got.active, got.kind, got.pred, got.ovr, got.miss);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (got.active !== want.active || got.kind !== want.kind ||
                    got.pred !== want.pred || got.ovr !== want.ovr ||
                    got.miss !== want.miss)
                begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS)
                    begin
                        $display("mismatch: exp active=%0d kind=%0d pred=%0d ovr=%0d miss=%0d",
                                 want.active, want.kind, want.pred, want.ovr, want.miss);
                        $display("          got active=%0d kind=%0d pred=%0d ovr=%0d miss=%0d",
                                 got.active, got.kind, got.pred, got.ovr, got.miss);
                    end
                end
            end
        end
    end

    // Watchdog, far above the slowest legal run.
    initial
    begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
